// File: rtl/core/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg - shared types and constants for the LRU cache lookup block
// Defaults for the geometry, channel widths, controller states and the
// command group from controller to datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package salru_pkg;

	// default cache geometry
	localparam int DEF_OFFSET_BITS = 6;
	localparam int DEF_INDEX_BITS  = 8;
	localparam int DEF_WAYS        = 4;

	// channel widths (fixed by the field list)
	localparam int ADDR_W      = 32;
	localparam int CNT_W       = 32;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 200;

	// controller states
	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} salru_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic rd_en;   // read set rows for the accepted word
		logic upd;     // update set rows, counters and output word
	} salru_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/set_assoc_cache_lru_lookup_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_top - set-associative write-back cache lookup
// Tag/state side of a write-back cache with true LRU replacement and
// saturating access statistics.
//
//  channel   dir  tdata                               tuser
//  s_axis    in   [31:0] address                      [0] req_type
//  m_axis    out  hit, back_invalidate, evict_address,
//                 writeback, five 32-bit counters     -
//
//  Each access is a registered read of the set's tag and state rows,
//  then a compare, update and write-back to the same rows.
//  Reset needs no clearing pass: per-set written flags give reset LRU/fill.
//  A result not yet taken holds the next access in its update step.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_lookup_top
	import salru_pkg::*;
#(
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int INDEX_BITS  = DEF_INDEX_BITS,
	parameter int WAYS        = DEF_WAYS
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire [IN_TDATA_W-1:0]   s_axis_tdata,  // [31:0] address
	input  wire                    s_axis_tuser,  // [0] req_type
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	// [0] hit, [1] back_invalidate, [33:2] evict_address, [34] writeback,
	// [66:35] access_total, [98:67] hit_total, [130:99] miss_total,
	// [162:131] writeback_total, [194:163] traffic_total, rest zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	salru_cmd_t cmd;

	salru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	salru_dp #(
		.OFFSET_BITS (OFFSET_BITS),
		.INDEX_BITS  (INDEX_BITS),
		.WAYS        (WAYS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_addr  (s_axis_tdata),
		.in_wr    (s_axis_tuser),
		.out_word (m_axis_tdata)
	);

endmodule

`default_nettype wire

// File: rtl/core/salru_ctrl.sv
// ----------------------------------------------------------------------------
// salru_ctrl - lookup sequencer
// Two-step sequence per access (read set, then update), plus output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_ctrl
	import salru_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire        out_ready,
	output salru_cmd_t cmd
);

	salru_state_t state_q, state_d;
	logic         out_vld_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.rd_en  = 1'b0;
		cmd.upd    = 1'b0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.rd_en = in_valid;
				if (in_valid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				// wait here while the previous result is still unclaimed
				if (!out_vld_q || out_ready) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.upd) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid = out_vld_q;

endmodule

`default_nettype wire

// File: rtl/core/salru_dp.sv
// ----------------------------------------------------------------------------
// salru_dp - cache tag/state datapath
// Tag and set-state memories, tag compare, LRU update, victim choice,
// saturating counters and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_dp
	import salru_pkg::*;
#(
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int INDEX_BITS  = DEF_INDEX_BITS,
	parameter int WAYS        = DEF_WAYS
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  salru_cmd_t             cmd,
	input  wire [ADDR_W-1:0]       in_addr,
	input  wire                    in_wr,
	output logic [OUT_TDATA_W-1:0] out_word
);

	localparam int NSETS = 1 << INDEX_BITS;
	localparam int TAGW  = ADDR_W - OFFSET_BITS - INDEX_BITS;
	localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FW    = $clog2(WAYS + 1);
	localparam int STW   = FW + WAYS + WAYS * WB;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
	endfunction

	// memories: one row per set
	logic [WAYS*TAGW-1:0] tag_mem [NSETS];
	logic [STW-1:0]       st_mem  [NSETS];
	logic [NSETS-1:0]     row_vld_q;

	logic [ADDR_W-1:0]     addr_s1;
	logic                  wr_s1;
	logic [WAYS*TAGW-1:0]  tag_row_s1;
	logic [STW-1:0]        st_row_s1;
	logic                  row_vld_s1;

	logic [INDEX_BITS-1:0] in_set, set_s1;
	logic [TAGW-1:0]       tag_s1;

	assign in_set = in_addr[OFFSET_BITS +: INDEX_BITS];
	assign set_s1 = addr_s1[OFFSET_BITS +: INDEX_BITS];
	assign tag_s1 = addr_s1[ADDR_W-1 -: TAGW];

	// read stage: capture request and set rows
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			addr_s1    <= in_addr;
			wr_s1      <= in_wr;
			tag_row_s1 <= tag_mem[in_set];
			st_row_s1  <= st_mem[in_set];
		end
	end

	// per-set written flags stand in for the reset state of st_mem
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			row_vld_s1 <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				row_vld_s1 <= row_vld_q[in_set];
			end
			if (cmd.upd) begin
				row_vld_q[set_s1] <= 1'b1;
			end
		end
	end

	// unpack set state, reset values for a never-written set
	logic [FW-1:0]   fill;
	logic [WAYS-1:0] dirty;
	logic [WB-1:0]   lru [WAYS];

	always_comb begin
		fill  = '0;
		dirty = '0;
		for (int k = 0; k < WAYS; k++) begin
			lru[k] = WB'(k);
		end
		if (row_vld_s1) begin
			fill  = st_row_s1[FW-1:0];
			dirty = st_row_s1[FW +: WAYS];
			for (int k = 0; k < WAYS; k++) begin
				lru[k] = st_row_s1[FW + WAYS + k*WB +: WB];
			end
		end
	end

	// tag compare, first matching valid way wins
	logic          hit;
	logic [WB-1:0] hit_way;

	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if ((FW'(w) < fill) && (tag_row_s1[w*TAGW +: TAGW] == tag_s1)) begin
				hit     = 1'b1;
				hit_way = WB'(w);
			end
		end
	end

	// way choice: hit way, next empty way, or LRU way
	logic          full;
	logic          evict;
	logic [WB-1:0] way;

	assign full  = (fill == FW'(WAYS));
	assign evict = !hit && full;

	always_comb begin
		if (hit) begin
			way = hit_way;
		end else if (!full) begin
			way = fill[WB-1:0];
		end else begin
			way = lru[WAYS-1];
		end
	end

	// move chosen way to MRU position
	logic [WB-1:0] pos;
	logic [WB-1:0] lru_new [WAYS];

	always_comb begin
		pos = WB'(WAYS - 1);
		for (int k = WAYS - 2; k >= 0; k--) begin
			if (lru[k] == way) begin
				pos = WB'(k);
			end
		end
		lru_new[0] = way;
		for (int k = 1; k < WAYS; k++) begin
			lru_new[k] = (WB'(k) <= pos) ? lru[k-1] : lru[k];
		end
	end

	// next row contents
	logic [WAYS*TAGW-1:0] tag_row_new;
	logic [STW-1:0]       st_row_new;
	logic [WAYS-1:0]      dirty_new;
	logic [FW-1:0]        fill_new;
	logic [TAGW-1:0]      vic_tag;
	logic                 wb;

	always_comb begin
		tag_row_new = tag_row_s1;
		dirty_new   = dirty;
		fill_new    = fill;
		vic_tag     = tag_row_s1[way*TAGW +: TAGW];
		wb          = evict && dirty[way];
		if (hit) begin
			if (wr_s1) begin
				dirty_new[way] = 1'b1;
			end
		end else begin
			tag_row_new[way*TAGW +: TAGW] = tag_s1;
			dirty_new[way]                = wr_s1;
			if (!full) begin
				fill_new = fill + FW'(1);
			end
		end
		st_row_new = {STW{1'b0}};
		st_row_new[FW-1:0]     = fill_new;
		st_row_new[FW +: WAYS] = dirty_new;
		for (int k = 0; k < WAYS; k++) begin
			st_row_new[FW + WAYS + k*WB +: WB] = lru_new[k];
		end
	end

	// memory write-back
	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			tag_mem[set_s1] <= tag_row_new;
			st_mem[set_s1]  <= st_row_new;
		end
	end

	// saturating counters
	logic [CNT_W-1:0] acc_q, hit_cnt_q, miss_q, wb_cnt_q, trf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			hit_cnt_q <= '0;
			miss_q    <= '0;
			wb_cnt_q  <= '0;
			trf_q     <= '0;
		end else if (cmd.upd) begin
			acc_q <= sat_inc(acc_q);
			if (hit) begin
				hit_cnt_q <= sat_inc(hit_cnt_q);
			end else begin
				miss_q <= sat_inc(miss_q);
			end
			if (wb) begin
				wb_cnt_q <= sat_inc(wb_cnt_q);
			end
			if ((hit && !wr_s1) || evict) begin
				trf_q <= sat_inc(trf_q);
			end
		end
	end

	// result word: counters shown after this access is counted
	logic [ADDR_W-1:0] evict_addr;

	assign evict_addr = evict ? {vic_tag, set_s1, {OFFSET_BITS{1'b0}}} : '0;

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			out_word <= {5'b0,
				(hit && !wr_s1) || evict ? sat_inc(trf_q) : trf_q,
				wb ? sat_inc(wb_cnt_q) : wb_cnt_q,
				hit ? miss_q : sat_inc(miss_q),
				hit ? sat_inc(hit_cnt_q) : hit_cnt_q,
				sat_inc(acc_q),
				wb, evict_addr, evict, hit};
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/salru_chk.sv
// ----------------------------------------------------------------------------
// salru_chk - port-level checks for the cache lookup block
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_chk
	import salru_pkg::*;
(
	input wire                   clk,
	input wire                   arst_n,
	input wire                   s_axis_tvalid,
	input wire                   s_axis_tready,
	input wire                   m_axis_tvalid,
	input wire                   m_axis_tready,
	input wire [OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// one access in flight: no accept in the cycle after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted a word during lookup");

	// an eviction only happens on a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("hit with back-invalidate");

	// writeback needs an eviction
	a_wb_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[1])
		else $error("writeback without eviction");

	// no evict address without eviction
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[33:2] == 32'd0)
		else $error("evict address without eviction");

endmodule

bind set_assoc_cache_lru_lookup_top salru_chk u_salru_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: test/tb_set_assoc_cache_lru_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_lookup_top - stream test of the LRU cache lookup
// Drives directed and random read/write accesses into the lookup block,
// predicts each result word with a behavioral cache model (tags, valid,
// dirty, true LRU order, fill counts, saturating counters) and compares
// every output word field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_set_assoc_cache_lru_lookup_top
	import salru_pkg::*;
;

	localparam int OFS      = DEF_OFFSET_BITS;
	localparam int IDX      = DEF_INDEX_BITS;
	localparam int NWAY     = DEF_WAYS;
	localparam int NSET     = 1 << IDX;
	localparam int TSH      = OFS + IDX;
	localparam int TAG_W    = ADDR_W - TSH;
	localparam int N_RAND   = 1650;
	localparam int MAX_CYC  = 400000;
	localparam bit REQ_RD   = 1'b0;
	localparam bit REQ_WR   = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0]  traffic_total;
		logic [CNT_W-1:0]  writeback_total;
		logic [CNT_W-1:0]  miss_total;
		logic [CNT_W-1:0]  hit_total;
		logic [CNT_W-1:0]  access_total;
		logic              writeback;
		logic [ADDR_W-1:0] evict_address;
		logic              back_invalidate;
		logic              hit;
	} lookup_word_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic              wr;
		bit                known;  // expected word typed in
		logic              e_hit;
		logic              e_binv;
		logic [ADDR_W-1:0] e_evict;
		logic              e_wb;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	set_assoc_cache_lru_lookup_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// cache model state
	logic [TAG_W-1:0] tags [NSET][NWAY];
	bit               vld  [NSET][NWAY];
	bit               drt  [NSET][NWAY];
	int unsigned      lru  [NSET][NWAY];
	int unsigned      fill [NSET];
	logic [CNT_W-1:0] c_acc, c_hit, c_miss, c_wb, c_trf;

	lookup_word_t expected_words[$];
	stim_row_t    dir_rows[$];
	int           errors = 0;
	int           cycles = 0;
	bit           quiet_src = 0, quiet_snk = 0;

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic void promote(int s, int unsigned w);
		int p;
		p = 0;
		while (p < NWAY - 1 && lru[s][p] != w) p++;
		for (int k = p; k > 0; k--) lru[s][k] = lru[s][k-1];
		lru[s][0] = w;
	endfunction

	function automatic lookup_word_t cache_access(logic [ADDR_W-1:0] a, logic wr);
		lookup_word_t r;
		int s;
		logic [TAG_W-1:0] t;
		int hw;
		int unsigned w;
		r = '0;
		s = (a >> OFS) & (NSET - 1);
		t = TAG_W'(a >> TSH);
		hw = -1;
		c_acc = sat_inc(c_acc);
		for (int k = 0; k < NWAY; k++)
			if (hw < 0 && vld[s][k] && tags[s][k] == t) hw = k;
		if (hw >= 0) begin
			r.hit = 1'b1;
			c_hit = sat_inc(c_hit);
			promote(s, hw);
			if (wr) drt[s][hw] = 1;
			else c_trf = sat_inc(c_trf);
		end else begin
			c_miss = sat_inc(c_miss);
			if (fill[s] < NWAY) begin
				w = fill[s];
				if (wr) drt[s][w] = 1;
				vld[s][w] = 1;
				tags[s][w] = t;
				promote(s, w);
				fill[s]++;
			end else begin
				w = lru[s][NWAY-1] % NWAY;
				if (drt[s][w]) begin
					r.writeback = 1'b1;
					c_wb = sat_inc(c_wb);
				end
				r.evict_address = ADDR_W'({tags[s][w], IDX'(s), OFS'(0)});
				r.back_invalidate = 1'b1;
				drt[s][w] = wr;
				tags[s][w] = t;
				promote(s, w);
				c_trf = sat_inc(c_trf);
			end
		end
		r.access_total = c_acc;
		r.hit_total = c_hit;
		r.miss_total = c_miss;
		r.writeback_total = c_wb;
		r.traffic_total = c_trf;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] mk_addr(int unsigned t, int unsigned s);
		return ADDR_W'({TAG_W'(t), IDX'(s), OFS'($urandom)});
	endfunction

	function automatic void add_row(logic [ADDR_W-1:0] a, logic wr, bit kn,
			logic h, logic b, logic [ADDR_W-1:0] e, logic wb);
		stim_row_t r;
		r.addr = a; r.wr = wr; r.known = kn;
		r.e_hit = h; r.e_binv = b; r.e_evict = e; r.e_wb = wb;
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// send one word, queue its prediction; valid drops only while idling
	task automatic send_word(logic [ADDR_W-1:0] a, logic wr, bit kn,
			logic h, logic b, logic [ADDR_W-1:0] e, logic wb);
		lookup_word_t p;
		while (!quiet_src && $urandom_range(99) < 27) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= a;
		s_axis_tuser  <= wr;
		p = cache_access(a, wr);
		if (kn && (p.hit !== h || p.back_invalidate !== b ||
				p.evict_address !== e || p.writeback !== wb))
			$display("%0t note: directed row disagrees with predictor", $time);
		if (kn) begin
			p.hit = h; p.back_invalidate = b; p.evict_address = e; p.writeback = wb;
		end
		expected_words.insert(expected_words.size(), p);
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// receiver side
	always @(negedge clk)
		m_axis_tready <= quiet_snk ? 1'b1 : ($urandom_range(99) >= 27);

	always @(posedge clk) begin
		lookup_word_t got, exp_w;
		cycles <= cycles + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = lookup_word_t'(m_axis_tdata[$bits(lookup_word_t)-1:0]);
			if (expected_words.size() == 0) begin
				$display("%0t unexpected word: %h", $time, got);
				errors++;
			end else begin
				exp_w = expected_words.pop_front();
				if (got.hit !== exp_w.hit || got.back_invalidate !== exp_w.back_invalidate ||
						got.evict_address !== exp_w.evict_address ||
						got.writeback !== exp_w.writeback ||
						got.access_total !== exp_w.access_total ||
						got.hit_total !== exp_w.hit_total ||
						got.miss_total !== exp_w.miss_total ||
						got.writeback_total !== exp_w.writeback_total ||
						got.traffic_total !== exp_w.traffic_total ||
						m_axis_tdata[OUT_TDATA_W-1:$bits(lookup_word_t)] !== '0) begin
					$display("%0t mismatch: expected %h actual %h", $time, exp_w,
						m_axis_tdata);
					errors++;
				end
			end
		end
	end

	always @(posedge clk)
		if (cycles > MAX_CYC) begin
			$display("RESULT: ERROR");
			$finish;
		end

	initial begin
		int unsigned t, s, n;
		for (int i = 0; i < NSET; i++) begin
			fill[i] = 0;
			for (int k = 0; k < NWAY; k++) begin
				tags[i][k] = '0; vld[i][k] = 0; drt[i][k] = 0; lru[i][k] = k;
			end
		end
		c_acc = '0; c_hit = '0; c_miss = '0; c_wb = '0; c_trf = '0;

		// directed: cold miss, hit, fill set 0, evictions clean and dirty, extremes
		add_row(32'h0000_0000, REQ_RD, 1, 0, 0, 32'h0, 0);
		add_row(32'h0000_003F, REQ_WR, 1, 1, 0, 32'h0, 0);
		add_row(32'h0000_4000, REQ_RD, 1, 0, 0, 32'h0, 0);
		add_row(32'h0000_8000, REQ_WR, 1, 0, 0, 32'h0, 0);
		add_row(32'h0000_C000, REQ_RD, 1, 0, 0, 32'h0, 0);
		// set 0 full, LRU is tag 0 (dirty)
		add_row(32'h0001_0000, REQ_RD, 1, 0, 1, 32'h0000_0000, 1);
		// next LRU tag 1, clean
		add_row(32'h0001_4000, REQ_WR, 1, 0, 1, 32'h0000_4000, 0);
		add_row(32'h0000_8010, REQ_RD, 1, 1, 0, 32'h0, 0);
		add_row(32'hFFFF_FFFF, REQ_WR, 1, 0, 0, 32'h0, 0);
		add_row(32'hFFFF_FFC0, REQ_RD, 1, 1, 0, 32'h0, 0);
		add_row(32'hFFFF_BFFF, REQ_RD, 0, 0, 0, 0, 0);
		add_row(32'hFFFF_7FFF, REQ_WR, 0, 0, 0, 0, 0);
		add_row(32'hFFFF_3FFF, REQ_RD, 0, 0, 0, 0, 0);
		add_row(32'hAAAA_AAAA, REQ_WR, 0, 0, 0, 0, 0);
		add_row(32'h5555_5555, REQ_RD, 0, 0, 0, 0, 0);
		add_row(32'h7FFF_FFFF, REQ_WR, 0, 0, 0, 0, 0);
		add_row(32'h8000_0000, REQ_RD, 0, 0, 0, 0, 0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].addr, dir_rows[i].wr, dir_rows[i].known,
				dir_rows[i].e_hit, dir_rows[i].e_binv, dir_rows[i].e_evict,
				dir_rows[i].e_wb);

		// random: mostly a few hot sets with a small tag pool for hits/evictions
		for (int i = 0; i < N_RAND; i++) begin
			quiet_src = (i >= 600 && i < 800);
			quiet_snk = (i >= 650 && i < 850);
			n = $urandom_range(99);
			if (n < 75) begin
				s = $urandom_range(7) * 37 % NSET;
				t = $urandom_range(6) + (s << 4);
				send_word(mk_addr(t, s), $urandom_range(1), 0, 0, 0, 0, 0);
			end else
				send_word($urandom, $urandom_range(1), 0, 0, 0, 0, 0);
		end
		quiet_src = 0; quiet_snk = 0;
		s_axis_tvalid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
